>>> hw/rtl/aabb_pkg.sv
// Package with shared types and constants for the bounding box overlap referee.
`default_nettype none
package aabb_pkg;
    localparam int MaxColliders = 16;
    localparam int SlotW = 4;
    localparam int CntW = 5;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SET = 2'd2,
        OP_CHECK = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        EV_ENTRY = 2'd0,
        EV_UPDATE = 2'd1,
        EV_EXIT = 2'd2,
        EV_DONE = 2'd3
    } t_event;

    localparam logic [1:0] KindNone = 2'd0;
    localparam logic [1:0] KindSolid = 2'd1;
    localparam logic [1:0] KindTrigger = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PAIR,
        ST_EMIT,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;      // capture the request
        logic do_list;    // apply add, remove or set
        logic step_shift; // one step of closing a gap
        logic load_pair;  // read the next list entry
        logic eval_pair;  // evaluate the pair and update kinds
        logic next_idx;   // advance walk index
        logic emit_pend;  // present the entry event
        logic emit_upd;   // present the pending update or exit event
        logic emit_done;  // present the done result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_check;
        logic slot_bad;
        logic walk_end;
        logic shift_end;
        logic skip_pair;
        logic has_event;
        logic has_entry;
        logic out_busy;
    } t_stat;
endpackage
`default_nettype wire

>>> hw/rtl/aabb_ctrl.sv
// Controller state machine for the bounding box overlap referee.
`default_nettype none
module aabb_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_req,
    input  aabb_pkg::t_stat     i_stat,
    output aabb_pkg::t_cmd      o_cmd,
    output logic                o_ready
);
    import aabb_pkg::*;

    t_state r_state, n_state;
    logic r_entry, n_entry;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_entry <= 1'b0;
        end else begin
            r_state <= n_state;
            r_entry <= n_entry;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_entry = r_entry;
        o_cmd = '0;
        o_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_req) begin
                    o_cmd.latch = 1'b1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Non-check requests finish list work here.
                if (!i_stat.op_check || i_stat.slot_bad) begin
                    if (i_stat.slot_bad) begin
                        n_state = ST_DONE;
                    end else if (i_stat.shift_end) begin
                        o_cmd.do_list = 1'b1;
                        n_state = ST_DONE;
                    end else begin
                        o_cmd.step_shift = 1'b1;
                    end
                end else if (i_stat.walk_end) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.load_pair = 1'b1;
                    n_state = ST_PAIR;
                end
            end
            ST_PAIR: begin
                o_cmd.next_idx = 1'b1;
                if (i_stat.skip_pair) begin
                    n_state = ST_SCAN;
                end else begin
                    o_cmd.eval_pair = 1'b1;
                    n_entry = i_stat.has_entry;
                    n_state = i_stat.has_event ? ST_EMIT : ST_SCAN;
                end
            end
            ST_EMIT: begin
                if (!i_stat.out_busy) begin
                    if (r_entry) begin
                        o_cmd.emit_pend = 1'b1;
                        n_entry = 1'b0;
                    end else begin
                        o_cmd.emit_upd = 1'b1;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.emit_done = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_done |=> r_state == ST_IDLE) else $error("done not to idle");
    a_eval_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.eval_pair |-> $past(o_cmd.load_pair)) else $error("eval without load");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/aabb_dp.sv
// Datapath: box store, active list and pair evaluation for the overlap referee.
`default_nettype none
module aabb_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  aabb_pkg::t_cmd      i_cmd,
    input  wire logic [1:0]     i_opcode,
    input  wire logic [3:0]     i_slot,
    input  wire logic signed [15:0] i_pos_x,
    input  wire logic signed [15:0] i_pos_y,
    input  wire logic [14:0]    i_box_width,
    input  wire logic [14:0]    i_box_height,
    input  wire logic           i_trigger,
    input  wire logic           i_out_ready,
    output aabb_pkg::t_stat     o_stat,
    output logic                o_out_valid,
    output logic [1:0]          o_event_res,
    output logic [3:0]          o_other_slot,
    output logic [1:0]          o_collision_state,
    output logic                o_last
);
    import aabb_pkg::*;

    logic signed [15:0] r_left [MaxColliders];
    logic signed [15:0] r_top [MaxColliders];
    logic [14:0] r_w [MaxColliders];
    logic [14:0] r_h [MaxColliders];
    logic [MaxColliders-1:0] r_trig;
    logic [1:0] r_kind [MaxColliders];
    logic [SlotW-1:0] r_order [MaxColliders];
    logic [CntW-1:0] r_count;

    t_opcode r_op;
    logic [SlotW-1:0] r_slot;
    logic signed [15:0] r_px, r_py;
    logic [14:0] r_pw, r_ph;
    logic r_ptrig;
    logic [CntW-1:0] r_idx;
    logic r_found;
    logic [SlotW-1:0] r_other;
    logic [1:0] r_run;
    logic r_valid;
    logic [1:0] r_ev;
    logic [3:0] r_oslot;
    logic [1:0] r_ostate;
    logic r_olast;

    logic slot_bad;
    logic [SlotW-1:0] cur;
    logic signed [16:0] sl, st, sr, sb, ol, ot, orr, ob;
    logic overlap, both_none, both_trig, o_trig;
    logic out_free;

    assign slot_bad = ({1'b0, r_slot} >= 5'(MaxColliders));
    assign cur = r_order[r_idx[SlotW-1:0]];
    assign out_free = !r_valid || i_out_ready;

    // Pair overlap test on 17-bit bounds.
    always_comb begin
        sl = 17'(r_left[r_slot]);
        st = 17'(r_top[r_slot]);
        sr = sl + 17'($signed({2'b00, r_w[r_slot]}));
        sb = st + 17'($signed({2'b00, r_h[r_slot]}));
        ol = 17'(r_left[r_other]);
        ot = 17'(r_top[r_other]);
        orr = ol + 17'($signed({2'b00, r_w[r_other]}));
        ob = ot + 17'($signed({2'b00, r_h[r_other]}));
        overlap = (sl < orr) && (sr > ol) && (st < ob) && (sb > ot);
        o_trig = r_trig[r_other];
        both_none = (r_kind[r_slot] == KindNone) && (r_kind[r_other] == KindNone);
        both_trig = (r_kind[r_slot] == KindTrigger) && (r_kind[r_other] == KindTrigger);
    end

    // Status to the controller.
    always_comb begin
        o_stat.op_check = (r_op == OP_CHECK);
        o_stat.slot_bad = slot_bad;
        o_stat.walk_end = (r_idx >= r_count);
        // Set finishes at once. Add and remove search the list first; add stops
        // on a duplicate, and remove then shifts later entries until the end.
        if (r_op == OP_ADD || r_op == OP_REMOVE) begin
            if (r_found) begin
                o_stat.shift_end = (r_op == OP_ADD) || (r_idx + 5'd1 >= r_count);
            end else begin
                o_stat.shift_end = (r_idx >= r_count);
            end
        end else begin
            o_stat.shift_end = 1'b1;
        end
        o_stat.skip_pair = (r_other == r_slot);
        o_stat.has_event = overlap || both_trig;
        o_stat.has_entry = overlap && o_trig && both_none;
        o_stat.out_busy = !out_free;
    end

    // Request capture, list search, shift and update, and walking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx <= '0;
            r_found <= 1'b0;
            r_run <= KindNone;
        end else begin
            if (i_cmd.latch) begin
                r_op <= t_opcode'(i_opcode);
                r_slot <= i_slot;
                r_px <= i_pos_x;
                r_py <= i_pos_y;
                r_pw <= i_box_width;
                r_ph <= i_box_height;
                r_ptrig <= i_trigger;
                r_idx <= '0;
                r_found <= 1'b0;
                r_run <= KindNone;
            end
            // Remove: locate, then move later entries down one place.
            if (i_cmd.step_shift) begin
                if (r_found) begin
                    r_order[r_idx[SlotW-1:0]] <= r_order[SlotW'(r_idx + 5'd1)];
                    r_idx <= r_idx + 5'd1;
                end else if (r_idx < r_count && cur == r_slot) begin
                    r_found <= 1'b1;
                end else if (r_idx < r_count) begin
                    r_idx <= r_idx + 5'd1;
                end else begin
                    r_found <= 1'b0;
                    r_idx <= r_count;
                end
            end
            if (i_cmd.do_list) begin
                case (r_op)
                    OP_ADD: begin
                        if (!r_found && r_count < 5'(MaxColliders)) begin
                            r_order[r_count[SlotW-1:0]] <= r_slot;
                            r_count <= r_count + 5'd1;
                        end
                    end
                    OP_REMOVE: if (r_found) r_count <= r_count - 5'd1;
                    default: ;
                endcase
            end
            if (i_cmd.load_pair) r_other <= cur;
            if (i_cmd.next_idx) r_idx <= r_idx + 5'd1;
            if (i_cmd.eval_pair) begin
                if (overlap) r_run <= o_trig ? KindTrigger : KindSolid;
                else if (both_trig) r_run <= KindNone;
            end
        end
    end

    // Add reuses the search: duplicate found sets r_found before do_list.
    // The search runs through step_shift too, which for add only advances the index
    // and sets r_found, so the duplicate test shares the remove search.

    // Box store and contact kinds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig <= '0;
            for (int k = 0; k < MaxColliders; k++) begin
                r_left[k] <= '0;
                r_top[k] <= '0;
                r_w[k] <= '0;
                r_h[k] <= '0;
                r_kind[k] <= KindNone;
            end
        end else begin
            if (i_cmd.do_list && r_op == OP_SET) begin
                r_left[r_slot] <= r_px;
                r_top[r_slot] <= r_py;
                r_w[r_slot] <= r_pw;
                r_h[r_slot] <= r_ph;
                r_trig[r_slot] <= r_ptrig;
            end
            if (i_cmd.eval_pair) begin
                if (overlap) begin
                    r_kind[r_slot] <= o_trig ? KindTrigger : KindSolid;
                    r_kind[r_other] <= o_trig ? KindTrigger : KindSolid;
                end else if (both_trig) begin
                    r_kind[r_slot] <= KindNone;
                    r_kind[r_other] <= KindNone;
                end
            end
        end
    end

    // Output register; a pending event is held in r_pend_* until emitted.
    logic [1:0] r_pend_ev;
    logic [1:0] r_pend_state;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.eval_pair) begin
                r_pend_ev <= overlap ? EV_UPDATE : EV_EXIT;
                r_pend_state <= overlap ? (o_trig ? KindTrigger : KindSolid) : KindNone;
            end
            if (i_cmd.emit_pend) begin
                r_valid <= 1'b1;
                r_ev <= EV_ENTRY;
                r_oslot <= r_other;
                r_ostate <= KindTrigger;
                r_olast <= 1'b0;
            end else if (i_cmd.emit_upd) begin
                r_valid <= 1'b1;
                r_ev <= r_pend_ev;
                r_oslot <= r_other;
                r_ostate <= r_pend_state;
                r_olast <= 1'b0;
            end else if (i_cmd.emit_done) begin
                r_valid <= 1'b1;
                r_ev <= EV_DONE;
                r_oslot <= '0;
                r_ostate <= (r_op == OP_CHECK && !slot_bad) ? r_run : KindNone;
                r_olast <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_event_res = r_ev;
    assign o_other_slot = r_oslot;
    assign o_collision_state = r_ostate;
    assign o_last = r_olast;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 5'(MaxColliders)) else $error("list overflow");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_out_ready) |=> r_valid) else $error("result lost");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_done |=> (r_olast && r_ev == EV_DONE)) else $error("bad done");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/aabb_collision_referee.sv
// Top level of the axis-aligned bounding box overlap referee.
// Add and remove scan the active list one entry per cycle, set writes the box
// store directly, and a check walks the list entry by entry, evaluating one
// pair at a time in the single shared pair-evaluation unit. Output
// back-pressure stalls the referee while an event or done result waits.
// A new request is taken only once the previous done result has been placed in
// the output register; that result may still wait.
`default_nettype none
module aabb_collision_referee (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: opcode[1:0], slot[5:2], pos_x[21:6], pos_y[37:22],
    // box_width[52:38], box_height[67:53], trigger[68], zero fill to 72
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: event_res[1:0], other_slot[5:2], collision_state[7:6]
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast
);
    import aabb_pkg::*;

    t_cmd cmd;
    t_stat stat;
    logic [1:0] ev, cs;
    logic [3:0] oslot;

    aabb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(s_axis_tvalid),
        .i_stat(stat), .o_cmd(cmd), .o_ready(s_axis_tready)
    );

    aabb_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_opcode(s_axis_tdata[1:0]), .i_slot(s_axis_tdata[5:2]),
        .i_pos_x(s_axis_tdata[21:6]), .i_pos_y(s_axis_tdata[37:22]),
        .i_box_width(s_axis_tdata[52:38]), .i_box_height(s_axis_tdata[67:53]),
        .i_trigger(s_axis_tdata[68]), .i_out_ready(m_axis_tready),
        .o_stat(stat), .o_out_valid(m_axis_tvalid), .o_event_res(ev),
        .o_other_slot(oslot), .o_collision_state(cs), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {cs, oslot, ev};
endmodule
`default_nettype wire
